[rtl/segi_pkg.sv]
package segi_pkg;

    typedef struct packed {
        logic valid;
        logic hit;
        logic neg_x;
        logic neg_y;
    } ctl_t;

    // front end 4, dividend build 2, output register 1; the divider adds COORD_BITS
    localparam int FIXED_LATENCY = 7;

endpackage

[rtl/segment_intersection.sv]
// Line segment intersection for segments A and B given as signed fixed-point endpoints
// (Q16.8 at the default COORD_BITS of 24). A beat is taken on any clock edge where start
// is high; busy is always low, so a new pair can go in every cycle. Each result comes out
// as a one-cycle done strobe with hit, cross_x and cross_y; results leave in input order
// and cannot be held off. The pipeline is four front-end stages (differences, products,
// cross products, decision), two stages building the dividend, one stage per quotient
// bit in the pipelined divider, and the output register. Rejection order: bounding box
// (touching passes), straddle test (a zero cross product passes), then parallel or
// degenerate segments. The offset from A's start point is truncated toward that point
// to one LSB; on a miss cross_x and cross_y read zero.
module segment_intersection #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] seg_a_start_x,
    input  logic signed [COORD_BITS-1:0] seg_a_start_y,
    input  logic signed [COORD_BITS-1:0] seg_a_end_x,
    input  logic signed [COORD_BITS-1:0] seg_a_end_y,
    input  logic signed [COORD_BITS-1:0] seg_b_start_x,
    input  logic signed [COORD_BITS-1:0] seg_b_start_y,
    input  logic signed [COORD_BITS-1:0] seg_b_end_x,
    input  logic signed [COORD_BITS-1:0] seg_b_end_y,
    output logic                         done,
    output logic                         hit,
    output logic signed [COORD_BITS-1:0] cross_x,
    output logic signed [COORD_BITS-1:0] cross_y
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int MW = 2 * C + 1;
    localparam int NW = C + MW;

    segi_pkg::ctl_t      fr_ctl, sc_ctl, dv_ctl;
    logic [MW-1:0]       fr_num_mag, fr_den_mag, sc_den;
    logic [C-1:0]        fr_dx_mag, fr_dy_mag, dv_q_x, dv_q_y;
    logic signed [C-1:0] fr_base_x, fr_base_y, sc_base_x, sc_base_y, dv_base_x, dv_base_y;
    logic [NW-1:0]       sc_n_x, sc_n_y;

    logic                done_reg, hit_reg;
    logic signed [C-1:0] cross_x_reg, cross_y_reg;
    logic [DW-1:0]       off_x, off_y, sum_x, sum_y;

    segi_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .seg_a_start_x (seg_a_start_x),
        .seg_a_start_y (seg_a_start_y),
        .seg_a_end_x   (seg_a_end_x),
        .seg_a_end_y   (seg_a_end_y),
        .seg_b_start_x (seg_b_start_x),
        .seg_b_start_y (seg_b_start_y),
        .seg_b_end_x   (seg_b_end_x),
        .seg_b_end_y   (seg_b_end_y),
        .ctl           (fr_ctl),
        .num_mag       (fr_num_mag),
        .den_mag       (fr_den_mag),
        .dx_mag        (fr_dx_mag),
        .dy_mag        (fr_dy_mag),
        .base_x        (fr_base_x),
        .base_y        (fr_base_y)
    );

    segi_scale #(
        .COORD_BITS(COORD_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (fr_ctl),
        .num_mag   (fr_num_mag),
        .den_mag   (fr_den_mag),
        .dx_mag    (fr_dx_mag),
        .dy_mag    (fr_dy_mag),
        .base_x_in (fr_base_x),
        .base_y_in (fr_base_y),
        .ctl       (sc_ctl),
        .n_x       (sc_n_x),
        .n_y       (sc_n_y),
        .den       (sc_den),
        .base_x    (sc_base_x),
        .base_y    (sc_base_y)
    );

    segi_div #(
        .COORD_BITS(COORD_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (sc_ctl),
        .n_x       (sc_n_x),
        .n_y       (sc_n_y),
        .den       (sc_den),
        .base_x_in (sc_base_x),
        .base_y_in (sc_base_y),
        .ctl       (dv_ctl),
        .q_x       (dv_q_x),
        .q_y       (dv_q_y),
        .base_x    (dv_base_x),
        .base_y    (dv_base_y)
    );

    always_comb
    begin
        off_x = dv_ctl.neg_x ? -DW'(dv_q_x) : DW'(dv_q_x);
        off_y = dv_ctl.neg_y ? -DW'(dv_q_y) : DW'(dv_q_y);
        sum_x = DW'(dv_base_x) + off_x;
        sum_y = DW'(dv_base_y) + off_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= dv_ctl.valid;
            hit_reg  <= dv_ctl.valid && dv_ctl.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        cross_x_reg <= dv_ctl.hit ? C'(sum_x) : '0;
        cross_y_reg <= dv_ctl.hit ? C'(sum_y) : '0;
    end

    assign busy    = 1'b0;
    assign done    = done_reg;
    assign hit     = hit_reg;
    assign cross_x = cross_x_reg;
    assign cross_y = cross_y_reg;

endmodule

[rtl/segi_front.sv]
module segi_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [COORD_BITS-1:0] seg_a_start_x,
    input  logic signed [COORD_BITS-1:0] seg_a_start_y,
    input  logic signed [COORD_BITS-1:0] seg_a_end_x,
    input  logic signed [COORD_BITS-1:0] seg_a_end_y,
    input  logic signed [COORD_BITS-1:0] seg_b_start_x,
    input  logic signed [COORD_BITS-1:0] seg_b_start_y,
    input  logic signed [COORD_BITS-1:0] seg_b_end_x,
    input  logic signed [COORD_BITS-1:0] seg_b_end_y,
    output segi_pkg::ctl_t               ctl,
    output logic [2*COORD_BITS:0]        num_mag,
    output logic [2*COORD_BITS:0]        den_mag,
    output logic [COORD_BITS-1:0]        dx_mag,
    output logic [COORD_BITS-1:0]        dy_mag,
    output logic signed [COORD_BITS-1:0] base_x,
    output logic signed [COORD_BITS-1:0] base_y
);

    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;
    localparam int XW = 2 * DW;
    localparam int MW = XW - 1;

    // stage 1: differences and box extents
    logic                 s1_valid_reg;
    logic signed [DW-1:0] s1_dx1_reg, s1_dy1_reg, s1_dx2_reg, s1_dy2_reg;
    logic signed [DW-1:0] s1_ex_reg, s1_ey_reg, s1_fx_reg, s1_fy_reg, s1_gx_reg, s1_gy_reg;
    logic signed [C-1:0]  s1_ax_lo_reg, s1_ax_hi_reg, s1_ay_lo_reg, s1_ay_hi_reg;
    logic signed [C-1:0]  s1_bx_lo_reg, s1_bx_hi_reg, s1_by_lo_reg, s1_by_hi_reg;
    logic signed [C-1:0]  s1_base_x_reg, s1_base_y_reg;

    // stage 2: products
    logic                 s2_valid_reg;
    logic                 s2_box_ok_reg;
    logic signed [XW-1:0] s2_num_a_reg, s2_num_b_reg, s2_x2_a_reg, s2_x2_b_reg;
    logic signed [XW-1:0] s2_x3_a_reg, s2_x3_b_reg, s2_x4_a_reg, s2_x4_b_reg;
    logic signed [XW-1:0] s2_den_a_reg, s2_den_b_reg;
    logic signed [DW-1:0] s2_dx1_reg, s2_dy1_reg;
    logic signed [C-1:0]  s2_base_x_reg, s2_base_y_reg;

    // stage 3: cross products
    logic                 s3_valid_reg;
    logic                 s3_box_ok_reg;
    logic signed [XW-1:0] s3_num_reg, s3_x2_reg, s3_x3_reg, s3_x4_reg, s3_den_reg;
    logic signed [DW-1:0] s3_dx1_reg, s3_dy1_reg;
    logic signed [C-1:0]  s3_base_x_reg, s3_base_y_reg;

    // stage 4: decision and magnitudes
    segi_pkg::ctl_t       ctl_reg, ctl_next;
    logic [MW-1:0]        num_mag_reg, den_mag_reg;
    logic [C-1:0]         dx_mag_reg, dy_mag_reg;
    logic signed [C-1:0]  base_x_reg, base_y_reg;

    logic box_ok_next;
    logic num_neg, num_pos, x2_neg, x2_pos, x3_neg, x3_pos, x4_neg, x4_pos;
    logic den_zero, rej_a, rej_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            ctl_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            ctl_reg      <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_dx1_reg <= DW'(seg_a_end_x) - DW'(seg_a_start_x);
        s1_dy1_reg <= DW'(seg_a_end_y) - DW'(seg_a_start_y);
        s1_dx2_reg <= DW'(seg_b_end_x) - DW'(seg_b_start_x);
        s1_dy2_reg <= DW'(seg_b_end_y) - DW'(seg_b_start_y);
        s1_ex_reg  <= DW'(seg_b_start_x) - DW'(seg_a_start_x);
        s1_ey_reg  <= DW'(seg_b_start_y) - DW'(seg_a_start_y);
        s1_fx_reg  <= DW'(seg_a_end_x) - DW'(seg_b_start_x);
        s1_fy_reg  <= DW'(seg_a_end_y) - DW'(seg_b_start_y);
        s1_gx_reg  <= DW'(seg_b_end_x) - DW'(seg_a_start_x);
        s1_gy_reg  <= DW'(seg_b_end_y) - DW'(seg_a_start_y);
        s1_ax_lo_reg <= (seg_a_start_x < seg_a_end_x) ? seg_a_start_x : seg_a_end_x;
        s1_ax_hi_reg <= (seg_a_start_x < seg_a_end_x) ? seg_a_end_x : seg_a_start_x;
        s1_ay_lo_reg <= (seg_a_start_y < seg_a_end_y) ? seg_a_start_y : seg_a_end_y;
        s1_ay_hi_reg <= (seg_a_start_y < seg_a_end_y) ? seg_a_end_y : seg_a_start_y;
        s1_bx_lo_reg <= (seg_b_start_x < seg_b_end_x) ? seg_b_start_x : seg_b_end_x;
        s1_bx_hi_reg <= (seg_b_start_x < seg_b_end_x) ? seg_b_end_x : seg_b_start_x;
        s1_by_lo_reg <= (seg_b_start_y < seg_b_end_y) ? seg_b_start_y : seg_b_end_y;
        s1_by_hi_reg <= (seg_b_start_y < seg_b_end_y) ? seg_b_end_y : seg_b_start_y;
        s1_base_x_reg <= seg_a_start_x;
        s1_base_y_reg <= seg_a_start_y;

        s2_box_ok_reg <= box_ok_next;
        s2_num_a_reg  <= XW'(s1_ex_reg)  * XW'(s1_dy2_reg);
        s2_num_b_reg  <= XW'(s1_ey_reg)  * XW'(s1_dx2_reg);
        s2_x2_a_reg   <= XW'(s1_fx_reg)  * XW'(s1_dy2_reg);
        s2_x2_b_reg   <= XW'(s1_fy_reg)  * XW'(s1_dx2_reg);
        s2_x3_a_reg   <= XW'(s1_ex_reg)  * XW'(s1_dy1_reg);
        s2_x3_b_reg   <= XW'(s1_ey_reg)  * XW'(s1_dx1_reg);
        s2_x4_a_reg   <= XW'(s1_gx_reg)  * XW'(s1_dy1_reg);
        s2_x4_b_reg   <= XW'(s1_gy_reg)  * XW'(s1_dx1_reg);
        s2_den_a_reg  <= XW'(s1_dx1_reg) * XW'(s1_dy2_reg);
        s2_den_b_reg  <= XW'(s1_dy1_reg) * XW'(s1_dx2_reg);
        s2_dx1_reg    <= s1_dx1_reg;
        s2_dy1_reg    <= s1_dy1_reg;
        s2_base_x_reg <= s1_base_x_reg;
        s2_base_y_reg <= s1_base_y_reg;

        s3_box_ok_reg <= s2_box_ok_reg;
        s3_num_reg    <= s2_num_a_reg - s2_num_b_reg;
        s3_x2_reg     <= s2_x2_a_reg - s2_x2_b_reg;
        s3_x3_reg     <= s2_x3_a_reg - s2_x3_b_reg;
        s3_x4_reg     <= s2_x4_a_reg - s2_x4_b_reg;
        s3_den_reg    <= s2_den_a_reg - s2_den_b_reg;
        s3_dx1_reg    <= s2_dx1_reg;
        s3_dy1_reg    <= s2_dy1_reg;
        s3_base_x_reg <= s2_base_x_reg;
        s3_base_y_reg <= s2_base_y_reg;

        num_mag_reg <= s3_num_reg[XW-1] ? MW'(-s3_num_reg) : MW'(s3_num_reg);
        den_mag_reg <= s3_den_reg[XW-1] ? MW'(-s3_den_reg) : MW'(s3_den_reg);
        dx_mag_reg  <= s3_dx1_reg[DW-1] ? C'(-s3_dx1_reg) : C'(s3_dx1_reg);
        dy_mag_reg  <= s3_dy1_reg[DW-1] ? C'(-s3_dy1_reg) : C'(s3_dy1_reg);
        base_x_reg  <= s3_base_x_reg;
        base_y_reg  <= s3_base_y_reg;
    end

    // touching boxes pass
    assign box_ok_next = !((s1_ax_hi_reg < s1_bx_lo_reg) || (s1_ay_hi_reg < s1_by_lo_reg) ||
                           (s1_bx_hi_reg < s1_ax_lo_reg) || (s1_by_hi_reg < s1_ay_lo_reg));

    // num is (B.start - A.start) x dB, the negation of A.start's straddle product
    always_comb
    begin
        num_neg  = s3_num_reg[XW-1];
        num_pos  = !num_neg && (s3_num_reg != '0);
        x2_neg   = s3_x2_reg[XW-1];
        x2_pos   = !x2_neg && (s3_x2_reg != '0);
        x3_neg   = s3_x3_reg[XW-1];
        x3_pos   = !x3_neg && (s3_x3_reg != '0);
        x4_neg   = s3_x4_reg[XW-1];
        x4_pos   = !x4_neg && (s3_x4_reg != '0);
        den_zero = (s3_den_reg == '0);
        rej_a    = (num_neg && x2_pos) || (num_pos && x2_neg);
        rej_b    = (x3_pos && x4_pos) || (x3_neg && x4_neg);

        ctl_next.valid = s3_valid_reg;
        ctl_next.hit   = s3_box_ok_reg && !rej_a && !rej_b && !den_zero;
        ctl_next.neg_x = s3_dx1_reg[DW-1] ^ num_neg ^ s3_den_reg[XW-1];
        ctl_next.neg_y = s3_dy1_reg[DW-1] ^ num_neg ^ s3_den_reg[XW-1];
    end

    assign ctl     = ctl_reg;
    assign num_mag = num_mag_reg;
    assign den_mag = den_mag_reg;
    assign dx_mag  = dx_mag_reg;
    assign dy_mag  = dy_mag_reg;
    assign base_x  = base_x_reg;
    assign base_y  = base_y_reg;

endmodule

[rtl/segi_scale.sv]
module segi_scale #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  segi_pkg::ctl_t               ctl_in,
    input  logic [2*COORD_BITS:0]        num_mag,
    input  logic [2*COORD_BITS:0]        den_mag,
    input  logic [COORD_BITS-1:0]        dx_mag,
    input  logic [COORD_BITS-1:0]        dy_mag,
    input  logic signed [COORD_BITS-1:0] base_x_in,
    input  logic signed [COORD_BITS-1:0] base_y_in,
    output segi_pkg::ctl_t               ctl,
    output logic [3*COORD_BITS:0]        n_x,
    output logic [3*COORD_BITS:0]        n_y,
    output logic [2*COORD_BITS:0]        den,
    output logic signed [COORD_BITS-1:0] base_x,
    output logic signed [COORD_BITS-1:0] base_y
);

    localparam int C  = COORD_BITS;
    localparam int MW = 2 * C + 1;
    localparam int LW = C + 1;
    localparam int HW = MW - LW;
    localparam int NW = C + MW;

    // num magnitude split in two so each multiply is at most COORD_BITS by COORD_BITS+1 bits
    segi_pkg::ctl_t      s5_ctl_reg, ctl_reg;
    logic [C+LW-1:0]     s5_px_lo_reg, s5_py_lo_reg;
    logic [C+HW-1:0]     s5_px_hi_reg, s5_py_hi_reg;
    logic [MW-1:0]       s5_den_reg, den_reg;
    logic signed [C-1:0] s5_base_x_reg, s5_base_y_reg, base_x_reg, base_y_reg;
    logic [NW-1:0]       n_x_reg, n_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_ctl_reg <= '0;
            ctl_reg    <= '0;
        end
        else
        begin
            s5_ctl_reg <= ctl_in;
            ctl_reg    <= s5_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_px_lo_reg  <= (C+LW)'(dx_mag) * (C+LW)'(num_mag[LW-1:0]);
        s5_px_hi_reg  <= (C+HW)'(dx_mag) * (C+HW)'(num_mag[MW-1:LW]);
        s5_py_lo_reg  <= (C+LW)'(dy_mag) * (C+LW)'(num_mag[LW-1:0]);
        s5_py_hi_reg  <= (C+HW)'(dy_mag) * (C+HW)'(num_mag[MW-1:LW]);
        s5_den_reg    <= den_mag;
        s5_base_x_reg <= base_x_in;
        s5_base_y_reg <= base_y_in;

        n_x_reg    <= {s5_px_hi_reg, {LW{1'b0}}} + NW'(s5_px_lo_reg);
        n_y_reg    <= {s5_py_hi_reg, {LW{1'b0}}} + NW'(s5_py_lo_reg);
        den_reg    <= s5_den_reg;
        base_x_reg <= s5_base_x_reg;
        base_y_reg <= s5_base_y_reg;
    end

    assign ctl    = ctl_reg;
    assign n_x    = n_x_reg;
    assign n_y    = n_y_reg;
    assign den    = den_reg;
    assign base_x = base_x_reg;
    assign base_y = base_y_reg;

endmodule

[rtl/segi_div.sv]
module segi_div #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  segi_pkg::ctl_t               ctl_in,
    input  logic [3*COORD_BITS:0]        n_x,
    input  logic [3*COORD_BITS:0]        n_y,
    input  logic [2*COORD_BITS:0]        den,
    input  logic signed [COORD_BITS-1:0] base_x_in,
    input  logic signed [COORD_BITS-1:0] base_y_in,
    output segi_pkg::ctl_t               ctl,
    output logic [COORD_BITS-1:0]        q_x,
    output logic [COORD_BITS-1:0]        q_y,
    output logic signed [COORD_BITS-1:0] base_x,
    output logic signed [COORD_BITS-1:0] base_y
);

    localparam int C  = COORD_BITS;
    localparam int MW = 2 * C + 1;
    localparam int NW = C + MW;

    // restoring division, one quotient bit per stage; the quotient is below 2^C
    // so the upper dividend bits start out below the divisor
    segi_pkg::ctl_t      ctl_reg   [C];
    logic [MW-1:0]       rem_x_reg [C];
    logic [MW-1:0]       rem_y_reg [C];
    logic [C-1:0]        low_x_reg [C];
    logic [C-1:0]        low_y_reg [C];
    logic [MW-1:0]       den_reg   [C];
    logic signed [C-1:0] bx_reg    [C];
    logic signed [C-1:0] by_reg    [C];

    for (genvar k = 0; k < C; k++)
    begin : g_stage
        segi_pkg::ctl_t      ctl_cur;
        logic [MW-1:0]       rx_cur, ry_cur, d_cur;
        logic [C-1:0]        lx_cur, ly_cur;
        logic signed [C-1:0] bx_cur, by_cur;
        logic [MW:0]         tx, ty;
        logic                gx, gy;

        if (k == 0)
        begin : g_head
            assign ctl_cur = ctl_in;
            assign rx_cur  = n_x[NW-1 -: MW];
            assign ry_cur  = n_y[NW-1 -: MW];
            assign lx_cur  = n_x[C-1:0];
            assign ly_cur  = n_y[C-1:0];
            assign d_cur   = den;
            assign bx_cur  = base_x_in;
            assign by_cur  = base_y_in;
        end
        else
        begin : g_body
            assign ctl_cur = ctl_reg[k-1];
            assign rx_cur  = rem_x_reg[k-1];
            assign ry_cur  = rem_y_reg[k-1];
            assign lx_cur  = low_x_reg[k-1];
            assign ly_cur  = low_y_reg[k-1];
            assign d_cur   = den_reg[k-1];
            assign bx_cur  = bx_reg[k-1];
            assign by_cur  = by_reg[k-1];
        end

        assign tx = {rx_cur, lx_cur[C-1]};
        assign ty = {ry_cur, ly_cur[C-1]};
        assign gx = (tx >= {1'b0, d_cur});
        assign gy = (ty >= {1'b0, d_cur});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else
            begin
                ctl_reg[k] <= ctl_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_x_reg[k] <= gx ? MW'(tx - {1'b0, d_cur}) : MW'(tx);
            rem_y_reg[k] <= gy ? MW'(ty - {1'b0, d_cur}) : MW'(ty);
            low_x_reg[k] <= {lx_cur[C-2:0], gx};
            low_y_reg[k] <= {ly_cur[C-2:0], gy};
            den_reg[k]   <= d_cur;
            bx_reg[k]    <= bx_cur;
            by_reg[k]    <= by_cur;
        end
    end

    assign ctl    = ctl_reg[C-1];
    assign q_x    = low_x_reg[C-1];
    assign q_y    = low_y_reg[C-1];
    assign base_x = bx_reg[C-1];
    assign base_y = by_reg[C-1];

endmodule

[rtl/segi_chk.sv]
module segi_chk #(
    parameter int COORD_BITS = 24
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic signed [COORD_BITS-1:0] seg_a_start_x,
    input logic signed [COORD_BITS-1:0] seg_a_start_y,
    input logic signed [COORD_BITS-1:0] seg_a_end_x,
    input logic signed [COORD_BITS-1:0] seg_a_end_y,
    input logic                         done,
    input logic                         hit,
    input logic signed [COORD_BITS-1:0] cross_x,
    input logic signed [COORD_BITS-1:0] cross_y
);

    localparam int LAT = COORD_BITS + segi_pkg::FIXED_LATENCY;

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat produced no result at fixed latency");

    a_beat_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without a matching accepted beat");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (cross_x == '0) && (cross_y == '0))
        else $error("miss result carries nonzero point");

    a_hit_x: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |->
            ((cross_x >= $past(seg_a_start_x, LAT)) || (cross_x >= $past(seg_a_end_x, LAT))) &&
            ((cross_x <= $past(seg_a_start_x, LAT)) || (cross_x <= $past(seg_a_end_x, LAT))))
        else $error("hit x outside segment A extent");

    a_hit_y: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |->
            ((cross_y >= $past(seg_a_start_y, LAT)) || (cross_y >= $past(seg_a_end_y, LAT))) &&
            ((cross_y <= $past(seg_a_start_y, LAT)) || (cross_y <= $past(seg_a_end_y, LAT))))
        else $error("hit y outside segment A extent");

endmodule

bind segment_intersection segi_chk #(
    .COORD_BITS(COORD_BITS)
) u_segi_chk (.*);
